[hdl/zsu_pkg.sv]
package zsu_pkg;

    // Clamp limits for the geometry registers
    localparam logic [12:0] MAX_WIDTH  = 13'd4096;
    localparam logic [13:0] MAX_STRIDE = 14'd8192;

    // Configuration register indexes
    localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_LINE_STRIDE    = 3'd2;
    localparam logic [2:0] REG_PIXEL_DEPTH    = 3'd3;
    localparam logic [2:0] REG_MSB_BYTE_ORDER = 3'd4;
    localparam logic [2:0] REG_LSB_BIT_ORDER  = 3'd5;

    localparam int CFG_DATA_W = 14;

    // Slot width chosen from the pixel depth
    typedef enum logic [1:0] {
        SLOT4,
        SLOT8,
        SLOT16
    } slot_t;

    // One result word
    typedef struct packed {
        logic [15:0] pixel_value;
        logic        end_of_line;
        logic        end_of_image;
        logic        last_of_run;
    } result_t;

endpackage

[hdl/zpixmap_scanline_unpacker.sv]
// ZPixmap scanline unpacker: takes one raw dump byte per accepted word and
// returns the pixel values it holds, masked to the configured depth, with
// end-of-line, end-of-image and last-of-run flags. The byte is unpacked in
// the cycle it is accepted and its results land in a two-entry output
// buffer, so results appear in the cycle after the byte. With m_ready high
// one byte is taken per cycle for 8-bit and 16-bit slots (a 16-bit pixel
// needs two bytes); with 4-bit slots a byte yields up to two pixels and
// the next byte waits until the first is taken. Padding bytes up to the line
// stride are likewise consumed at one per cycle and give no result. Write
// the configuration registers only while no byte is in flight.
module zpixmap_scanline_unpacker
    import zsu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_pixel_value,
    output logic                  m_end_of_line,
    output logic                  m_end_of_image,
    output logic                  m_last_of_run
);

    // Configuration registers
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [13:0] line_stride_reg;
    logic [4:0]  pixel_depth_reg;
    logic        msb_byte_order_reg;
    logic        lsb_bit_order_reg;

    // Scan state
    logic [13:0] byte_in_line_reg, byte_in_line_next;
    logic [12:0] pixel_column_reg, pixel_column_next;
    logic [12:0] line_number_reg, line_number_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        half_pending_reg, half_pending_next;

    // Output buffer
    result_t     buf_reg [2];
    logic [1:0]  count_reg;

    // Derived geometry
    logic [4:0]  depth_eff;
    logic [12:0] width_eff;
    logic [12:0] height_eff;
    slot_t       slot;
    logic [16:0] mask_wide;
    logic [15:0] mask;
    logic [13:0] needed;
    logic [13:0] stride_clamp;
    logic [13:0] stride_eff;

    // Per-byte datapath
    logic        accept;
    logic        pop;
    logic [7:0]  in_byte;
    logic [15:0] val0;
    logic [15:0] val1;
    logic [1:0]  nv;
    logic [13:0] width14;
    logic [13:0] col_p1;
    logic [13:0] col_p2;
    logic        ok0;
    logic        ok1;
    logic        last_line;
    logic [14:0] byte_p1;
    logic [13:0] line_p1;
    result_t     res0;
    result_t     res1;

    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign s_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);

    assign m_pixel_value  = buf_reg[0].pixel_value;
    assign m_end_of_line  = buf_reg[0].end_of_line;
    assign m_end_of_image = buf_reg[0].end_of_image;
    assign m_last_of_run  = buf_reg[0].last_of_run;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg    <= 13'd1;
            image_height_reg   <= 13'd1;
            line_stride_reg    <= 14'd0;
            pixel_depth_reg    <= 5'd8;
            msb_byte_order_reg <= 1'b1;
            lsb_bit_order_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[12:0];
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data[12:0];
                REG_LINE_STRIDE:    line_stride_reg    <= cfg_data[13:0];
                REG_PIXEL_DEPTH:    pixel_depth_reg    <= cfg_data[4:0];
                REG_MSB_BYTE_ORDER: msb_byte_order_reg <= cfg_data[0];
                REG_LSB_BIT_ORDER:  lsb_bit_order_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the registers and derive slot, mask and line lengths
    always_comb begin
        if (pixel_depth_reg == 5'd0) begin
            depth_eff = 5'd1;
        end else if (pixel_depth_reg > 5'd16) begin
            depth_eff = 5'd16;
        end else begin
            depth_eff = pixel_depth_reg;
        end

        if (image_width_reg == 13'd0) begin
            width_eff = 13'd1;
        end else if (image_width_reg > MAX_WIDTH) begin
            width_eff = MAX_WIDTH;
        end else begin
            width_eff = image_width_reg;
        end

        height_eff = (image_height_reg == 13'd0) ? 13'd1 : image_height_reg;

        if (depth_eff == 5'd4) begin
            slot = SLOT4;
        end else if (depth_eff <= 5'd8) begin
            slot = SLOT8;
        end else begin
            slot = SLOT16;
        end

        mask_wide = (17'd1 << depth_eff) - 17'd1;
        mask      = mask_wide[15:0];

        case (slot)
            SLOT4:   needed = ({1'b0, width_eff} + 14'd1) >> 1;
            SLOT8:   needed = {1'b0, width_eff};
            SLOT16:  needed = {width_eff, 1'b0};
            default: needed = {1'b0, width_eff};
        endcase

        stride_clamp = (line_stride_reg > MAX_STRIDE) ? MAX_STRIDE : line_stride_reg;
        stride_eff   = (stride_clamp < needed) ? needed : stride_clamp;
    end

    // Unpack the incoming byte and advance the scan state
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            in_byte[i] = lsb_bit_order_reg ? s_data_byte[7-i] : s_data_byte[i];
        end

        width14   = {1'b0, width_eff};
        col_p1    = {1'b0, pixel_column_reg} + 14'd1;
        col_p2    = {1'b0, pixel_column_reg} + 14'd2;
        last_line = ({1'b0, line_number_reg} + 14'd1) >= {1'b0, height_eff};

        val0              = 16'd0;
        val1              = 16'd0;
        nv                = 2'd0;
        held_byte_next    = held_byte_reg;
        half_pending_next = half_pending_reg;

        if (byte_in_line_reg < needed) begin
            case (slot)
                SLOT4: begin
                    if (lsb_bit_order_reg) begin
                        val0 = {12'd0, in_byte[3:0]};
                        val1 = {12'd0, in_byte[7:4]};
                    end else begin
                        val0 = {12'd0, in_byte[7:4]};
                        val1 = {12'd0, in_byte[3:0]};
                    end
                    nv = (col_p1 < width14) ? 2'd2 : 2'd1;
                end
                SLOT8: begin
                    val0 = {8'd0, in_byte};
                    nv   = 2'd1;
                end
                SLOT16: begin
                    if (!half_pending_reg) begin
                        held_byte_next    = in_byte;
                        half_pending_next = 1'b1;
                    end else begin
                        val0 = msb_byte_order_reg ? {held_byte_reg, in_byte}
                                                  : {in_byte, held_byte_reg};
                        nv                = 2'd1;
                        half_pending_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        // Drop any pixel at or beyond the line width
        ok0 = (nv != 2'd0) && ({1'b0, pixel_column_reg} < width14);
        ok1 = (nv == 2'd2) && (col_p1 < width14);

        res0.pixel_value  = val0 & mask;
        res0.end_of_line  = (col_p1 == width14);
        res0.end_of_image = (col_p1 == width14) && last_line;
        res0.last_of_run  = !ok1;

        res1.pixel_value  = val1 & mask;
        res1.end_of_line  = (col_p2 == width14);
        res1.end_of_image = (col_p2 == width14) && last_line;
        res1.last_of_run  = 1'b1;

        if (ok1) begin
            pixel_column_next = col_p2[12:0];
        end else if (ok0) begin
            pixel_column_next = col_p1[12:0];
        end else begin
            pixel_column_next = pixel_column_reg;
        end

        byte_p1           = {1'b0, byte_in_line_reg} + 15'd1;
        line_p1           = {1'b0, line_number_reg} + 14'd1;
        byte_in_line_next = byte_p1[13:0];
        line_number_next  = line_number_reg;

        // Close the line once the stride is consumed
        if (byte_p1 >= {1'b0, stride_eff}) begin
            byte_in_line_next = 14'd0;
            pixel_column_next = 13'd0;
            half_pending_next = 1'b0;
            held_byte_next    = 8'd0;
            line_number_next  = (line_p1 >= {1'b0, height_eff}) ? 13'd0 : line_p1[12:0];
        end
    end

    // Hold scan state between words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_in_line_reg <= 14'd0;
            pixel_column_reg <= 13'd0;
            line_number_reg  <= 13'd0;
            held_byte_reg    <= 8'd0;
            half_pending_reg <= 1'b0;
        end else if (accept) begin
            byte_in_line_reg <= byte_in_line_next;
            pixel_column_reg <= pixel_column_next;
            line_number_reg  <= line_number_next;
            held_byte_reg    <= held_byte_next;
            half_pending_reg <= half_pending_next;
        end
    end

    // Fill the output buffer on accept, advance it on each taken result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (accept) begin
            count_reg <= {1'b0, ok0} + {1'b0, ok1};
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            buf_reg[0] <= res0;
            buf_reg[1] <= res1;
        end else if (pop) begin
            buf_reg[0] <= buf_reg[1];
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("output buffer count out of range");

    a_eoi_is_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_image) |-> m_end_of_line)
        else $error("end of image without end of line");

    a_eol_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_line) |-> m_last_of_run)
        else $error("result follows end of line within one byte");

    a_byte_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_in_line_reg < MAX_STRIDE)
        else $error("byte position beyond maximum stride");
`endif

endmodule
